[design/ple_pkg.sv]
// Shared types and codes for the positional list engine.
`default_nettype none

package ple_pkg;

  localparam int ACT_W  = 2;
  localparam int STAT_W = 2;

  // Requested action codes
  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_GET    = 2'd2
  } action_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_DONE   = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // Work handed from the front to the back
  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_INS  = 2'd1,
    OP_REM  = 2'd2,
    OP_GET  = 2'd3
  } op_t;

  typedef struct packed {
    op_t     op;
    status_t status;
  } cmd_ctl_t;

endpackage

`default_nettype wire

[design/ple_if.sv]
// Valid/ready channel interfaces for the request and result items.
`default_nettype none

interface ple_in_if #(
  parameter int POS_W = 5,
  parameter int EW    = 64
);
  logic                       valid;
  logic                       ready;
  logic [ple_pkg::ACT_W-1:0]  action;
  logic [POS_W-1:0]           position;
  logic [EW-1:0]              entry_in;

  modport source (output valid, action, position, entry_in, input ready);
  modport sink   (input valid, action, position, entry_in, output ready);
endinterface

interface ple_out_if #(
  parameter int CNT_W = 5,
  parameter int EW    = 64
);
  logic                       valid;
  logic                       ready;
  logic [ple_pkg::STAT_W-1:0] status;
  logic [EW-1:0]              entry_out;
  logic [CNT_W-1:0]           count_out;

  modport source (output valid, status, entry_out, count_out, input ready);
  modport sink   (input valid, status, entry_out, count_out, output ready);
endinterface

`default_nettype wire

[design/positional_list_engine.sv]
// Top level of the positional list engine: front, command queue and back.
//
//   channel   direction  handshake     payload
//   in_ch     sink       valid/ready   action, position, entry_in
//   out_ch    source     valid/ready   status, entry_out, count_out
//
// The back holds one item at a time and takes a new one only when no result
// waits: an insert at p moves count-p+1 entries and a remove at p moves
// count-p, count being the length before the item. Reset clears the count,
// the queue and the result valid flag; the entry memory is not cleared. The
// two-entry queue lets the front keep accepting items while the back shifts
// or while a result waits to be taken.
`default_nettype none

module positional_list_engine #(
  parameter int DEPTH      = 16,
  parameter int ENTRY_BITS = 64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ple_in_if.sink     in_ch,
  ple_out_if.source  out_ch
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int POS_W = $clog2(DEPTH + 2);
  localparam int CTL_W = $bits(ple_pkg::cmd_ctl_t);
  localparam int QW    = CTL_W + AW + CNT_W + ENTRY_BITS;

  ple_pkg::cmd_ctl_t     f_ctl, h_ctl;
  logic [AW-1:0]         f_idx, h_idx;
  logic [CNT_W-1:0]      f_cnt, h_cnt;
  logic [ENTRY_BITS-1:0] f_data, h_data;
  logic                  q_push, q_pop, q_full, q_empty;
  logic [QW-1:0]         q_din, q_dout;

  ple_front #(
    .DEPTH (DEPTH),
    .POS_W (POS_W),
    .CNT_W (CNT_W),
    .AW    (AW),
    .EW    (ENTRY_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .q_push   (q_push),
    .cmd_ctl  (f_ctl),
    .cmd_idx  (f_idx),
    .cmd_cnt  (f_cnt),
    .cmd_data (f_data)
  );

  // Pack and unpack queued commands
  assign q_din  = {f_ctl, f_idx, f_cnt, f_data};
  assign h_ctl  = ple_pkg::cmd_ctl_t'(q_dout[QW-1 -: CTL_W]);
  assign h_idx  = q_dout[AW+CNT_W+ENTRY_BITS-1 -: AW];
  assign h_cnt  = q_dout[CNT_W+ENTRY_BITS-1 -: CNT_W];
  assign h_data = q_dout[ENTRY_BITS-1:0];

  ple_queue #(
    .W  (QW),
    .QD (2)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  ple_back #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CNT_W (CNT_W),
    .EW    (ENTRY_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_ctl   (h_ctl),
    .q_idx   (h_idx),
    .q_cnt   (h_cnt),
    .q_data  (h_data),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  // Back never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("command popped from empty queue");

  // Reported count stays within capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.count_out <= CNT_W'(DEPTH)))
    else $error("result count exceeds capacity");

  // Failed results carry a zero entry
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != ple_pkg::ST_DONE) |-> (out_ch.entry_out == '0))
    else $error("failing result carries a nonzero entry");

  // Hold a waiting result unchanged until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.status) &&
      $stable(out_ch.entry_out) && $stable(out_ch.count_out)))
    else $error("waiting result changed before it was taken");

endmodule

`default_nettype wire

[design/ple_front.sv]
// Front end: accept request items, check them against the running count, classify.
`default_nettype none

module ple_front #(
  parameter int DEPTH = 16,
  parameter int POS_W = 5,
  parameter int CNT_W = 5,
  parameter int AW    = 4,
  parameter int EW    = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  ple_in_if.sink                 in_ch,
  input  wire logic              q_full,
  output logic                   q_push,
  output ple_pkg::cmd_ctl_t      cmd_ctl,
  output logic [AW-1:0]          cmd_idx,
  output logic [CNT_W-1:0]       cmd_cnt,
  output logic [EW-1:0]          cmd_data
);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [POS_W-1:0] cnt_ext;
  ple_pkg::action_t act;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;
  assign cmd_data    = in_ch.entry_in;
  assign cmd_idx     = AW'(in_ch.position - POS_W'(1));
  assign cnt_ext     = POS_W'(count_r);
  assign act         = ple_pkg::action_t'(in_ch.action);

  // Classify the request against the count left by earlier items
  always_comb begin
    cmd_ctl.op     = ple_pkg::OP_NONE;
    cmd_ctl.status = ple_pkg::ST_BADPOS;
    count_nxt      = count_r;
    unique case (act) inside
      ple_pkg::ACT_INSERT: begin
        if (in_ch.position == '0 || in_ch.position > cnt_ext + POS_W'(1)) begin
          cmd_ctl.status = ple_pkg::ST_BADPOS;
        end else if (count_r == CNT_W'(DEPTH)) begin
          cmd_ctl.status = ple_pkg::ST_FULL;
        end else begin
          cmd_ctl.op     = ple_pkg::OP_INS;
          cmd_ctl.status = ple_pkg::ST_DONE;
          count_nxt      = count_r + CNT_W'(1);
        end
      end
      ple_pkg::ACT_REMOVE, ple_pkg::ACT_GET: begin
        if (count_r == '0) begin
          cmd_ctl.status = ple_pkg::ST_EMPTY;
        end else if (in_ch.position == '0 || in_ch.position > cnt_ext) begin
          cmd_ctl.status = ple_pkg::ST_BADPOS;
        end else if (act == ple_pkg::ACT_GET) begin
          cmd_ctl.op     = ple_pkg::OP_GET;
          cmd_ctl.status = ple_pkg::ST_DONE;
        end else begin
          cmd_ctl.op     = ple_pkg::OP_REM;
          cmd_ctl.status = ple_pkg::ST_DONE;
          count_nxt      = count_r - CNT_W'(1);
        end
      end
      default: begin
        cmd_ctl.status = ple_pkg::ST_BADPOS;
      end
    endcase
  end

  assign cmd_cnt = count_nxt;

  // Advance the running count on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (q_push) begin
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

[design/ple_queue.sv]
// Short command queue between the front and the back.
`default_nettype none

module ple_queue #(
  parameter int W  = 8,
  parameter int QD = 2
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] din,
  input  wire logic         pop,
  output logic [W-1:0]      dout,
  output logic              full,
  output logic              empty
);

  localparam int PW = (QD > 1) ? $clog2(QD) : 1;
  localparam int CW = $clog2(QD + 1);

  logic [W-1:0]  slot_r [QD];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] fill_r;

  assign full  = (fill_r == CW'(QD));
  assign empty = (fill_r == '0);
  assign dout  = slot_r[rd_ptr_r];

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QD - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QD - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        fill_r <= fill_r + CW'(1);
      end else if (pop && !push) begin
        fill_r <= fill_r - CW'(1);
      end
    end
  end

  // Hold queued commands
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

endmodule

`default_nettype wire

[design/ple_back.sv]
// Back end: carry out commands on the entry memory and register the result item.
`default_nettype none

module ple_back #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int CNT_W = 5,
  parameter int EW    = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_empty,
  input  ple_pkg::cmd_ctl_t      q_ctl,
  input  wire logic [AW-1:0]     q_idx,
  input  wire logic [CNT_W-1:0]  q_cnt,
  input  wire logic [EW-1:0]     q_data,
  output logic                   q_pop,
  ple_out_if.source              out_ch
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_MOVE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Command in progress
  ple_pkg::op_t     op_r, op_nxt;
  ple_pkg::status_t status_r, status_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [EW-1:0]    data_r, data_nxt;

  // Shift sequencer
  logic [AW-1:0]    cur_r, cur_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic             pend_r, pend_nxt;
  logic [AW-1:0]    wa_r, wa_nxt;

  // Entry memory ports
  logic [EW-1:0]    mem_r [DEPTH];
  logic [EW-1:0]    rdata_r;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [EW-1:0]    wdata;
  logic [AW-1:0]    raddr;

  // Result register
  logic                       ov_r, ov_nxt;
  logic [ple_pkg::STAT_W-1:0] ostat_r, ostat_nxt;
  logic [EW-1:0]              oent_r, oent_nxt;
  logic [CNT_W-1:0]           ocnt_r, ocnt_nxt;

  assign out_ch.valid     = ov_r;
  assign out_ch.status    = ostat_r;
  assign out_ch.entry_out = oent_r;
  assign out_ch.count_out = ocnt_r;

  // Sequence each command: pop, walk the shift or read the entry, then post the result
  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    status_nxt = status_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    data_nxt   = data_r;
    cur_nxt    = cur_r;
    left_nxt   = left_r;
    pend_nxt   = pend_r;
    wa_nxt     = wa_r;
    q_pop      = 1'b0;
    we         = 1'b0;
    waddr      = wa_r;
    wdata      = rdata_r;
    raddr      = cur_r;
    ov_nxt     = ov_r && !out_ch.ready;
    ostat_nxt  = ostat_r;
    oent_nxt   = oent_r;
    ocnt_nxt   = ocnt_r;

    unique case (state_r)
      S_IDLE: begin
        if (!q_empty && !ov_r) begin
          q_pop      = 1'b1;
          op_nxt     = q_ctl.op;
          status_nxt = q_ctl.status;
          idx_nxt    = q_idx;
          cnt_nxt    = q_cnt;
          data_nxt   = q_data;
          pend_nxt   = 1'b0;
          unique case (q_ctl.op)
            ple_pkg::OP_NONE: begin
              ov_nxt    = 1'b1;
              ostat_nxt = q_ctl.status;
              oent_nxt  = '0;
              ocnt_nxt  = q_cnt;
            end
            ple_pkg::OP_GET: begin
              raddr     = q_idx;
              state_nxt = S_READ;
            end
            ple_pkg::OP_INS: begin
              // walk down from the old last entry to the insert point
              cur_nxt   = AW'(q_cnt - CNT_W'(2));
              left_nxt  = q_cnt - CNT_W'(1) - CNT_W'(q_idx);
              state_nxt = S_MOVE;
            end
            ple_pkg::OP_REM: begin
              // walk up from just past the removed entry to the old last one
              cur_nxt   = q_idx + AW'(1);
              left_nxt  = q_cnt - CNT_W'(q_idx);
              state_nxt = S_MOVE;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_READ: begin
        ov_nxt    = 1'b1;
        ostat_nxt = status_r;
        oent_nxt  = rdata_r;
        ocnt_nxt  = cnt_r;
        state_nxt = S_IDLE;
      end
      S_MOVE: begin
        // write back the entry read in the previous cycle
        if (pend_r) begin
          we    = 1'b1;
          waddr = wa_r;
          wdata = rdata_r;
        end
        if (left_r != '0) begin
          raddr    = cur_r;
          pend_nxt = 1'b1;
          left_nxt = left_r - CNT_W'(1);
          if (op_r == ple_pkg::OP_INS) begin
            wa_nxt  = cur_r + AW'(1);
            cur_nxt = cur_r - AW'(1);
          end else begin
            wa_nxt  = cur_r - AW'(1);
            cur_nxt = cur_r + AW'(1);
          end
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            if (op_r == ple_pkg::OP_INS) begin
              we    = 1'b1;
              waddr = idx_r;
              wdata = data_r;
            end
            ov_nxt    = 1'b1;
            ostat_nxt = status_r;
            oent_nxt  = '0;
            ocnt_nxt  = cnt_r;
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Payload and sequencer registers
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    status_r <= status_nxt;
    idx_r    <= idx_nxt;
    cnt_r    <= cnt_nxt;
    data_r   <= data_nxt;
    cur_r    <= cur_nxt;
    left_r   <= left_nxt;
    wa_r     <= wa_nxt;
    ostat_r  <= ostat_nxt;
    oent_r   <= oent_nxt;
    ocnt_r   <= ocnt_nxt;
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

endmodule

`default_nettype wire
